[design/fsps_pkg.sv]
package fsps_pkg;

  localparam int SLOTS  = 3;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int LCD_W   = 12;
  localparam int SEQ_W   = 32;
  localparam int IMG_W   = 16;
  localparam int PIX_W   = 24;
  localparam int PAD_W   = 4;
  localparam int SLOTF_W = 2;
  localparam int MASK_W  = 3;

  localparam logic [LCD_W-1:0] LCD_WIDTH_RST  = 12'd480;
  localparam logic [LCD_W-1:0] LCD_HEIGHT_RST = 12'd800;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SLOTS-1:0]  slot_mask_t;
  typedef logic [SEQ_W-1:0]  seq_t;

  typedef enum logic {
    REG_LCD_WIDTH  = 1'b0,
    REG_LCD_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_ARRIVED = 2'd0,
    MODE_DECODED = 2'd1,
    MODE_COPIED  = 2'd2,
    MODE_RELOAD  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_COPY   = 2'd2,
    CMD_SWITCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CHROMA_420   = 2'd0,
    CHROMA_444   = 2'd1,
    CHROMA_422   = 2'd2,
    CHROMA_OTHER = 2'd3
  } chroma_e;

  typedef enum logic [3:0] {
    PH_WAIT   = 4'b0001,
    PH_DECODE = 4'b0010,
    PH_COPY   = 4'b0100,
    PH_RELOAD = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       found;
    slot_t      best;
    slot_mask_t freed;
  } pick_t;

  typedef struct packed {
    logic [LCD_W-1:0] x_off;
    logic [LCD_W-1:0] y_off;
    logic [PIX_W-1:0] pix_off;
    logic [PAD_W-1:0] pad;
  } geom_t;

endpackage

[design/fsps_pick.sv]
module fsps_pick import fsps_pkg::*; (
  input  slot_mask_t ready_i,
  input  seq_t       seq_i [SLOTS],
  output pick_t      pick_o
);

  always_comb begin
    logic  found;
    slot_t best;
    seq_t  best_seq;
    found    = 1'b0;
    best     = '0;
    best_seq = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (ready_i[i] && (!found || seq_i[i] > best_seq)) begin
        found    = 1'b1;
        best     = SLOT_W'(i);
        best_seq = seq_i[i];
      end
    end
    pick_o.found = found;
    pick_o.best  = best;
    pick_o.freed = '0;
    for (int i = 0; i < SLOTS; i++) begin
      pick_o.freed[i] = found && ready_i[i] && (SLOT_W'(i) != best);
    end
  end

endmodule

[design/fsps_geom.sv]
module fsps_geom import fsps_pkg::*; (
  input  logic [LCD_W-1:0] lcd_width_i,
  input  logic [LCD_W-1:0] lcd_height_i,
  input  logic [IMG_W-1:0] image_width_i,
  input  logic [IMG_W-1:0] image_height_i,
  input  logic [1:0]       chroma_i,
  output geom_t            geom_o
);

  logic [LCD_W-1:0]   x_diff;
  logic [LCD_W-1:0]   y_diff;
  logic [LCD_W-1:0]   x_off;
  logic [LCD_W-1:0]   y_off;
  logic [2*LCD_W-1:0] row_base;
  logic [2:0]         pad8;

  always_comb begin
    x_diff = lcd_width_i - image_width_i[LCD_W-1:0];
    y_diff = lcd_height_i - image_height_i[LCD_W-1:0];
    x_off  = (IMG_W'(lcd_width_i) > image_width_i) ? (x_diff >> 1) : '0;
    y_off  = (IMG_W'(lcd_height_i) > image_height_i) ? (y_diff >> 1) : '0;
    pad8   = 3'd0 - image_width_i[2:0];
  end

  assign row_base = y_off * lcd_width_i;

  always_comb begin
    geom_o.x_off   = x_off;
    geom_o.y_off   = y_off;
    geom_o.pix_off = PIX_W'(row_base) + PIX_W'(x_off);
    case (chroma_i)
      CHROMA_420, CHROMA_422: geom_o.pad = PAD_W'(4'd0 - image_width_i[3:0]);
      CHROMA_444:             geom_o.pad = {1'b0, pad8};
      default:                geom_o.pad = '0;
    endcase
  end

endmodule

[design/frame_slot_pipeline_sequencer.sv]
// An accepted item passes the input register, then the result register, whose output
// is the result item. Throughput: one item per cycle while the result is not stalled;
// the slot pick and the offset multiply sit between the two registers. A stalled result
// holds while one more item waits in the input stage.
// Reset: asynchronous, active low; phase waits for a frame, no slot ready, stamps zero,
// display size 480 x 800, both stages empty.
module frame_slot_pipeline_sequencer import fsps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [LCD_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [SLOTF_W-1:0] arrived_slot_i,
  input  logic [SEQ_W-1:0]   arrival_seq_i,
  input  logic [IMG_W-1:0]   image_width_i,
  input  logic [IMG_W-1:0]   image_height_i,
  input  logic [1:0]         chroma_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         command_o,
  output logic [SLOTF_W-1:0] command_slot_o,
  output logic [MASK_W-1:0]  freed_mask_o,
  output logic [LCD_W-1:0]   x_offset_o,
  output logic [LCD_W-1:0]   y_offset_o,
  output logic [PIX_W-1:0]   pixel_offset_o,
  output logic [PAD_W-1:0]   line_pad_o,
  output logic [IMG_W-1:0]   copy_width_o,
  output logic [IMG_W-1:0]   copy_height_o
);

  logic [LCD_W-1:0] lcd_width_q, lcd_height_q;

  logic               in_valid_q;
  logic [1:0]         mode_q;
  logic [SLOTF_W-1:0] aslot_q;
  logic [SEQ_W-1:0]   aseq_q;
  logic [IMG_W-1:0]   iw_q, ih_q;
  logic [1:0]         chroma_q;

  phase_e     phase_q, phase_d;
  slot_t      cur_q, cur_d;
  slot_mask_t ready_q, ready_d;
  seq_t       seq_q [SLOTS];
  seq_t       seq_d [SLOTS];

  logic               out_valid_q;
  logic [1:0]         cmd_d, cmd_q;
  logic [SLOTF_W-1:0] cslot_d, cslot_q;
  logic [MASK_W-1:0]  freed_d, freed_q;
  geom_t              geom_d, geom_q;
  logic [IMG_W-1:0]   cw_d, cw_q, ch_d, ch_q;

  logic       advance;
  logic       fire;
  logic       aslot_ok;
  slot_t      aslot;
  slot_mask_t cur_mask;
  slot_mask_t arr_ready, rel_ready, pick_ready;
  seq_t       arr_seq [SLOTS];
  seq_t       pick_seq [SLOTS];
  pick_t      pick;
  geom_t      geom;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcd_width_q  <= LCD_WIDTH_RST;
      lcd_height_q <= LCD_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_LCD_WIDTH:  lcd_width_q  <= cfg_data_i;
        REG_LCD_HEIGHT: lcd_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      mode_q   <= mode_i;
      aslot_q  <= arrived_slot_i;
      aseq_q   <= arrival_seq_i;
      iw_q     <= image_width_i;
      ih_q     <= image_height_i;
      chroma_q <= chroma_i;
    end
  end

  assign aslot    = SLOT_W'(aslot_q);
  assign aslot_ok = 32'(aslot_q) < SLOTS;

  always_comb begin
    arr_ready = ready_q;
    for (int i = 0; i < SLOTS; i++) begin
      arr_seq[i] = seq_q[i];
      if (aslot_ok && aslot == SLOT_W'(i)) begin
        arr_ready[i] = 1'b1;
        arr_seq[i]   = aseq_q;
      end
    end
    cur_mask = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (cur_q == SLOT_W'(i)) begin
        cur_mask[i] = 1'b1;
      end
    end
    rel_ready = ready_q & ~cur_mask;
    pick_ready = (mode_e'(mode_q) == MODE_ARRIVED) ? arr_ready : rel_ready;
    for (int i = 0; i < SLOTS; i++) begin
      pick_seq[i] = (mode_e'(mode_q) == MODE_ARRIVED) ? arr_seq[i] : seq_q[i];
    end
  end

  fsps_pick u_pick (
    .ready_i (pick_ready),
    .seq_i   (pick_seq),
    .pick_o  (pick)
  );

  fsps_geom u_geom (
    .lcd_width_i    (lcd_width_q),
    .lcd_height_i   (lcd_height_q),
    .image_width_i  (iw_q),
    .image_height_i (ih_q),
    .chroma_i       (chroma_q),
    .geom_o         (geom)
  );

  always_comb begin
    phase_d = phase_q;
    cur_d   = cur_q;
    ready_d = ready_q;
    seq_d   = seq_q;
    cmd_d   = CMD_NONE;
    cslot_d = '0;
    freed_d = '0;
    geom_d  = '0;
    cw_d    = '0;
    ch_d    = '0;
    case (mode_e'(mode_q))
      MODE_ARRIVED: begin
        ready_d = arr_ready;
        seq_d   = arr_seq;
        if (phase_q == PH_WAIT && pick.found) begin
          ready_d = arr_ready & ~pick.freed;
          freed_d = MASK_W'(pick.freed);
          cur_d   = pick.best;
          phase_d = PH_DECODE;
          cmd_d   = CMD_DECODE;
          cslot_d = SLOTF_W'(pick.best);
        end
      end
      MODE_DECODED: begin
        geom_d  = geom;
        cw_d    = iw_q;
        ch_d    = ih_q;
        phase_d = PH_COPY;
        cmd_d   = CMD_COPY;
        cslot_d = SLOTF_W'(cur_q);
      end
      MODE_COPIED: begin
        if (phase_q == PH_COPY) begin
          phase_d = PH_RELOAD;
          cmd_d   = CMD_SWITCH;
          cslot_d = SLOTF_W'(cur_q);
        end
      end
      MODE_RELOAD: begin
        if (phase_q == PH_RELOAD) begin
          ready_d = rel_ready;
          freed_d = MASK_W'(cur_mask);
          phase_d = PH_WAIT;
          if (pick.found) begin
            ready_d = rel_ready & ~pick.freed;
            freed_d = MASK_W'(cur_mask | pick.freed);
            cur_d   = pick.best;
            phase_d = PH_DECODE;
            cmd_d   = CMD_DECODE;
            cslot_d = SLOTF_W'(pick.best);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      cur_q   <= '0;
      ready_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        seq_q[i] <= '0;
      end
    end else if (fire) begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      ready_q <= ready_d;
      seq_q   <= seq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cmd_q   <= cmd_d;
      cslot_q <= cslot_d;
      freed_q <= freed_d;
      geom_q  <= geom_d;
      cw_q    <= cw_d;
      ch_q    <= ch_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign command_o      = cmd_q;
  assign command_slot_o = cslot_q;
  assign freed_mask_o   = freed_q;
  assign x_offset_o     = geom_q.x_off;
  assign y_offset_o     = geom_q.y_off;
  assign pixel_offset_o = geom_q.pix_off;
  assign line_pad_o     = geom_q.pad;
  assign copy_width_o   = cw_q;
  assign copy_height_o  = ch_q;

endmodule

[test/frame_slot_pipeline_sequencer_test.sv]
`timescale 1ns / 100ps

module frame_slot_pipeline_sequencer_test;
  import fsps_pkg::*;

  localparam int LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    mode_e              mode;
    logic [SLOTF_W-1:0] slot;
    logic [SEQ_W-1:0]   seq;
    logic [IMG_W-1:0]   w;
    logic [IMG_W-1:0]   h;
    chroma_e            chroma;
  } frame_event_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [SLOTF_W-1:0] slot;
    logic [MASK_W-1:0]  freed;
    logic [LCD_W-1:0]   x_off;
    logic [LCD_W-1:0]   y_off;
    logic [PIX_W-1:0]   pix;
    logic [PAD_W-1:0]   pad;
    logic [IMG_W-1:0]   cw;
    logic [IMG_W-1:0]   ch;
  } pipe_cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_index_i = 1'b0;
  logic [LCD_W-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i = '0;
  logic [SLOTF_W-1:0] arrived_slot_i = '0;
  logic [SEQ_W-1:0]   arrival_seq_i = '0;
  logic [IMG_W-1:0]   image_width_i = '0;
  logic [IMG_W-1:0]   image_height_i = '0;
  logic [1:0]         chroma_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         command_o;
  logic [SLOTF_W-1:0] command_slot_o;
  logic [MASK_W-1:0]  freed_mask_o;
  logic [LCD_W-1:0]   x_offset_o;
  logic [LCD_W-1:0]   y_offset_o;
  logic [PIX_W-1:0]   pixel_offset_o;
  logic [PAD_W-1:0]   line_pad_o;
  logic [IMG_W-1:0]   copy_width_o;
  logic [IMG_W-1:0]   copy_height_o;

  frame_slot_pipeline_sequencer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .arrived_slot_i (arrived_slot_i),
    .arrival_seq_i  (arrival_seq_i),
    .image_width_i  (image_width_i),
    .image_height_i (image_height_i),
    .chroma_i       (chroma_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .command_o      (command_o),
    .command_slot_o (command_slot_o),
    .freed_mask_o   (freed_mask_o),
    .x_offset_o     (x_offset_o),
    .y_offset_o     (y_offset_o),
    .pixel_offset_o (pixel_offset_o),
    .line_pad_o     (line_pad_o),
    .copy_width_o   (copy_width_o),
    .copy_height_o  (copy_height_o)
  );

  always #2 clk_i = ~clk_i;

  phase_e             ph;
  logic [SLOTF_W-1:0] cur_slot;
  bit                 ready [SLOTS];
  logic [SEQ_W-1:0]   stamp [SLOTS];
  logic [LCD_W-1:0]   disp_w;
  logic [LCD_W-1:0]   disp_h;
  logic [SEQ_W-1:0]   seq_clock;

  pipe_cmd_t due_cmds [$];
  pipe_cmd_t want_cmd;
  pipe_cmd_t got_cmd;
  int        err_count = 0;
  int        cycle_count = 0;
  bit        idle_on = 1'b1;
  bit        hold_req = 1'b0;
  bit        hold_on = 1'b0;
  int        rx_burst = 0;

  function automatic void reset_sequencer();
    ph = PH_WAIT;
    cur_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      ready[i] = 1'b0;
      stamp[i] = '0;
    end
    disp_w = LCD_WIDTH_RST;
    disp_h = LCD_HEIGHT_RST;
    seq_clock = '0;
  endfunction

  function automatic bit pick_latest(inout logic [MASK_W-1:0] freed);
    int best;
    bit found;
    best = 0;
    found = 1'b0;
    if (ph != PH_WAIT) return 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (ready[i] && (!found || stamp[i] > stamp[best])) begin
        best = i;
        found = 1'b1;
      end
    end
    if (!found) return 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i != best && ready[i]) begin
        ready[i] = 1'b0;
        freed[i] = 1'b1;
      end
    end
    cur_slot = SLOTF_W'(best);
    ph = PH_DECODE;
    return 1'b1;
  endfunction

  function automatic pipe_cmd_t next_command(input frame_event_t ev);
    pipe_cmd_t r;
    logic [MASK_W-1:0] freed;
    int unsigned iw;
    int unsigned ih;
    int unsigned xo;
    int unsigned yo;
    int unsigned po;
    r = '0;
    freed = '0;
    case (ev.mode)
      MODE_ARRIVED: begin
        if (ev.slot < SLOTS) begin
          ready[ev.slot] = 1'b1;
          stamp[ev.slot] = ev.seq;
        end
        if (pick_latest(freed)) begin
          r.cmd = CMD_DECODE;
          r.slot = cur_slot;
        end
      end
      MODE_DECODED: begin
        iw = ev.w;
        ih = ev.h;
        xo = (iw < disp_w) ? (disp_w - iw) / 2 : 0;
        yo = (ih < disp_h) ? (disp_h - ih) / 2 : 0;
        po = yo * disp_w + xo;
        r.x_off = xo[LCD_W-1:0];
        r.y_off = yo[LCD_W-1:0];
        r.pix = po[PIX_W-1:0];
        case (ev.chroma)
          CHROMA_420, CHROMA_422: r.pad = PAD_W'((16 - iw % 16) % 16);
          CHROMA_444: r.pad = PAD_W'((8 - iw % 8) % 8);
          default: r.pad = '0;
        endcase
        r.cw = ev.w;
        r.ch = ev.h;
        ph = PH_COPY;
        r.cmd = CMD_COPY;
        r.slot = cur_slot;
      end
      MODE_COPIED: begin
        if (ph == PH_COPY) begin
          ph = PH_RELOAD;
          r.cmd = CMD_SWITCH;
          r.slot = cur_slot;
        end
      end
      default: begin
        if (ph == PH_RELOAD) begin
          ready[cur_slot] = 1'b0;
          freed[cur_slot] = 1'b1;
          ph = PH_WAIT;
          if (pick_latest(freed)) begin
            r.cmd = CMD_DECODE;
            r.slot = cur_slot;
          end
        end
      end
    endcase
    r.freed = freed;
    return r;
  endfunction

  function automatic frame_event_t arrival(input int slot, input logic [SEQ_W-1:0] seq);
    frame_event_t ev;
    ev = '0;
    ev.mode = MODE_ARRIVED;
    ev.slot = SLOTF_W'(slot);
    ev.seq = seq;
    return ev;
  endfunction

  function automatic frame_event_t decoded(input logic [IMG_W-1:0] w,
                                           input logic [IMG_W-1:0] h, input chroma_e c);
    frame_event_t ev;
    ev = '0;
    ev.mode = MODE_DECODED;
    ev.w = w;
    ev.h = h;
    ev.chroma = c;
    return ev;
  endfunction

  function automatic frame_event_t signal(input mode_e m);
    frame_event_t ev;
    ev = '0;
    ev.mode = m;
    return ev;
  endfunction

  function automatic frame_event_t random_event();
    frame_event_t ev;
    ev.mode = mode_e'($urandom_range(0, 3));
    ev.slot = SLOTF_W'($urandom_range(0, 3));
    ev.seq = $urandom;
    ev.w = IMG_W'($urandom_range(0, 65535));
    ev.h = IMG_W'($urandom_range(0, 65535));
    ev.chroma = chroma_e'($urandom_range(0, 3));
    if ($urandom_range(0, 4) != 0) begin
      ev.slot = SLOTF_W'($urandom_range(0, SLOTS - 1));
      seq_clock = seq_clock + $urandom_range(0, 3);
      if ($urandom_range(0, 7) != 0) ev.seq = seq_clock;
      if ($urandom_range(0, 3) != 0) begin
        ev.w = IMG_W'($urandom_range(0, 4200));
        ev.h = IMG_W'($urandom_range(0, 4200));
      end
      case (ph)
        PH_WAIT: ev.mode = MODE_ARRIVED;
        PH_DECODE: ev.mode = ($urandom_range(0, 2) == 0) ? MODE_ARRIVED : MODE_DECODED;
        PH_COPY: ev.mode = ($urandom_range(0, 2) == 0) ? MODE_ARRIVED : MODE_COPIED;
        default: ev.mode = ($urandom_range(0, 2) == 0) ? MODE_ARRIVED : MODE_RELOAD;
      endcase
    end
    return ev;
  endfunction

  task automatic send_event(input frame_event_t ev);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= ev.mode;
    arrived_slot_i <= ev.slot;
    arrival_seq_i <= ev.seq;
    image_width_i <= ev.w;
    image_height_i <= ev.h;
    chroma_i <= ev.chroma;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    due_cmds.push_back(next_command(ev));
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_display(input logic [LCD_W-1:0] w, input logic [LCD_W-1:0] h);
    wait_all_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_LCD_WIDTH;
    cfg_data_i <= w;
    @(negedge clk_i);
    cfg_index_i <= REG_LCD_HEIGHT;
    cfg_data_i <= h;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    disp_w = w;
    disp_h = h;
  endtask

  task automatic test_pipeline_cases();
    send_event(signal(MODE_RELOAD));
    send_event(signal(MODE_COPIED));
    send_event(arrival(3, 32'h0000_1234));
    send_event(arrival(0, 32'd5));
    send_event(arrival(1, 32'hFFFF_FFFF));
    send_event(arrival(2, 32'hFFFF_FFFF));
    send_event(signal(MODE_RELOAD));
    send_event(signal(MODE_COPIED));
    send_event(decoded(16'd0, 16'd0, CHROMA_420));
    send_event(signal(MODE_COPIED));
    send_event(arrival(3, 32'd0));
    send_event(signal(MODE_RELOAD));
    send_event(decoded(16'hFFFF, 16'hFFFF, CHROMA_444));
    send_event(decoded(16'd17, 16'd799, CHROMA_422));
    send_event(signal(MODE_COPIED));
    send_event(signal(MODE_COPIED));
    send_event(signal(MODE_RELOAD));
    send_event(decoded(16'd479, 16'd1, CHROMA_OTHER));
    send_event(signal(MODE_COPIED));
    send_event(signal(MODE_RELOAD));
    send_event(arrival(2, 32'd0));
  endtask

  task automatic test_display_sizes();
    set_display(12'd4095, 12'd4095);
    send_event(decoded(16'd0, 16'd0, CHROMA_420));
    set_display(12'd1, 12'd1);
    send_event(decoded(16'd0, 16'd1, CHROMA_444));
    set_display(12'd0, 12'd0);
    send_event(decoded(16'd0, 16'd0, CHROMA_422));
    set_display(12'd4095, 12'd0);
    send_event(decoded(16'd3, 16'd0, CHROMA_420));
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 250 == 0) set_display(LCD_W'($urandom_range(0, 4095)),
                                    LCD_W'($urandom_range(0, 4095)));
      send_event(random_event());
    end
  endtask

  task automatic test_output_hold(input int count);
    wait_all_results();
    hold_req = 1'b1;
    for (int i = 0; i < count; i++) send_event(random_event());
  endtask

  task automatic test_input_pause(input int count);
    for (int i = 0; i < count; i++) send_event(random_event());
    wait_all_results();
    for (int i = 0; i < count; i++) send_event(random_event());
  endtask

  task automatic test_back_to_back(input int count);
    set_display(12'd480, 12'd800);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) send_event(random_event());
  endtask

  always begin
    wait (hold_req);
    @(posedge clk_i);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on = 1'b0;
    hold_req = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rx_burst > 0) begin
      rx_burst--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_burst = $urandom_range(1, 5);
    end
    out_stall_i <= hold_on || (rx_burst > 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_cmds.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("cycle %0d: result with no command pending", cycle_count);
      end else begin
        want_cmd = due_cmds.pop_front();
        got_cmd.cmd = cmd_e'(command_o);
        got_cmd.slot = command_slot_o;
        got_cmd.freed = freed_mask_o;
        got_cmd.x_off = x_offset_o;
        got_cmd.y_off = y_offset_o;
        got_cmd.pix = pixel_offset_o;
        got_cmd.pad = line_pad_o;
        got_cmd.cw = copy_width_o;
        got_cmd.ch = copy_height_o;
        if (got_cmd !== want_cmd) begin
          err_count++;
          if (err_count <= 10) begin
            $display("cycle %0d: want cmd=%0d slot=%0d freed=%b x=%0d y=%0d pix=%0d pad=%0d",
                     cycle_count, want_cmd.cmd, want_cmd.slot, want_cmd.freed,
                     want_cmd.x_off, want_cmd.y_off, want_cmd.pix, want_cmd.pad);
            $display("  want w=%0d h=%0d; got cmd=%0d slot=%0d freed=%b x=%0d y=%0d",
                     want_cmd.cw, want_cmd.ch, got_cmd.cmd, got_cmd.slot, got_cmd.freed,
                     got_cmd.x_off, got_cmd.y_off);
            $display("  got pix=%0d pad=%0d w=%0d h=%0d",
                     got_cmd.pix, got_cmd.pad, got_cmd.cw, got_cmd.ch);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    reset_sequencer();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_pipeline_cases();
    test_display_sizes();
    test_random_traffic(1100);
    test_output_hold(50);
    test_input_pause(30);
    test_back_to_back(300);
    wait_all_results();
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && due_cmds.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
